/* hdl/rmr_pkg.sv */
package rmr_pkg;

  localparam int MAX_REGION_PIXELS = 262144;

  localparam int PIX_W   = 8;
  localparam int CNT_W   = $clog2(MAX_REGION_PIXELS + 1);
  localparam int SUM_W   = $clog2(MAX_REGION_PIXELS * 255 + 1);
  localparam int MEAN_W  = 8;
  localparam int STEP_W  = $clog2(MEAN_W);
  localparam int DVS_W   = CNT_W + MEAN_W - 1;
  localparam int CMP_W   = (SUM_W > DVS_W) ? SUM_W : DVS_W;
  localparam int Q_DEPTH = 2;
  localparam int QPTR_W  = $clog2(Q_DEPTH);
  localparam int QCNT_W  = $clog2(Q_DEPTH + 1);
  localparam int OUT_W   = 24;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] count;
    logic [PIX_W-1:0] spread;
    logic             similar;
    logic             overflow;
  } region_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_DONE
  } back_state_t;

endpackage

/* hdl/rmr_front.sv */
module rmr_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      threshold_we,
  input  logic [7:0]                threshold,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [rmr_pkg::PIX_W-1:0] pixel,
  input  logic                      last,
  input  logic                      q_full,
  output logic                      q_push,
  output rmr_pkg::region_t          q_data
);
  import rmr_pkg::*;

  logic [7:0]       thr;
  logic [SUM_W-1:0] pixel_sum, pixel_sum_next;
  logic [CNT_W-1:0] pixel_count, pixel_count_next;
  logic [PIX_W-1:0] min_seen, min_seen_next;
  logic [PIX_W-1:0] max_seen, max_seen_next;
  logic             count_overflow, count_overflow_next;
  logic             accept;
  logic [PIX_W-1:0] spread;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;
  assign q_push   = accept && last;

  always_comb begin
    pixel_sum_next      = pixel_sum;
    pixel_count_next    = pixel_count;
    count_overflow_next = count_overflow;
    if (pixel_count < CNT_W'(MAX_REGION_PIXELS)) begin
      pixel_sum_next   = pixel_sum + SUM_W'(pixel);
      pixel_count_next = pixel_count + CNT_W'(1);
    end else begin
      count_overflow_next = 1'b1;
    end
    min_seen_next = (pixel < min_seen) ? pixel : min_seen;
    max_seen_next = (pixel > max_seen) ? pixel : max_seen;
    spread        = max_seen_next - min_seen_next;

    q_data.sum      = pixel_sum_next;
    q_data.count    = pixel_count_next;
    q_data.spread   = spread;
    q_data.similar  = (spread <= thr);
    q_data.overflow = count_overflow_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= '0;
    end else if (threshold_we) begin
      thr <= threshold;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_sum      <= '0;
      pixel_count    <= '0;
      min_seen       <= '1;
      max_seen       <= '0;
      count_overflow <= 1'b0;
    end else if (accept) begin
      if (last) begin
        // region done, start afresh
        pixel_sum      <= '0;
        pixel_count    <= '0;
        min_seen       <= '1;
        max_seen       <= '0;
        count_overflow <= 1'b0;
      end else begin
        pixel_sum      <= pixel_sum_next;
        pixel_count    <= pixel_count_next;
        min_seen       <= min_seen_next;
        max_seen       <= max_seen_next;
        count_overflow <= count_overflow_next;
      end
    end
  end

endmodule

/* hdl/rmr_queue.sv */
module rmr_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  rmr_pkg::region_t push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output rmr_pkg::region_t pop_data
);
  import rmr_pkg::*;

  region_t           entries [Q_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;

  assign full      = (fill == QCNT_W'(Q_DEPTH));
  assign not_empty = (fill != '0);
  assign pop_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + QCNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - QCNT_W'(1);
      end
    end
  end

endmodule

/* hdl/rmr_back.sv */
module rmr_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      q_valid,
  input  rmr_pkg::region_t          q_data,
  output logic                      q_pop,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [rmr_pkg::OUT_W-1:0] m_tdata
);
  import rmr_pkg::*;

  back_state_t       state, state_next;
  logic [STEP_W-1:0] step;
  logic [SUM_W-1:0]  rem;
  logic [DVS_W-1:0]  dvs;
  logic [MEAN_W-1:0] quot;
  logic [PIX_W-1:0]  spread;
  logic              similar;
  logic              overflow;
  logic              fits;
  logic              load_out;

  // restoring division, one quotient bit a cycle; the mean always fits 8 bits
  assign fits = CMP_W'(rem) >= CMP_W'(dvs);

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    load_out   = 1'b0;
    case (state)
      BK_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          state_next = BK_DIV;
        end
      end
      BK_DIV: begin
        if (step == '0) begin
          state_next = BK_DONE;
        end
      end
      BK_DONE: begin
        if (!m_tvalid || m_tready) begin
          load_out   = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      rem      <= q_data.sum;
      dvs      <= DVS_W'(q_data.count) << (MEAN_W - 1);
      quot     <= '0;
      step     <= STEP_W'(MEAN_W - 1);
      spread   <= q_data.spread;
      similar  <= q_data.similar;
      overflow <= q_data.overflow;
    end else if (state == BK_DIV) begin
      if (fits) begin
        rem <= SUM_W'(CMP_W'(rem) - CMP_W'(dvs));
      end
      quot <= {quot[MEAN_W-2:0], fits};
      dvs  <= dvs >> 1;
      step <= step - STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= OUT_W'({overflow, similar, spread, quot});
    end
  end

endmodule

/* hdl/region_mean_and_range_test_core.sv */
// region mean and range test
// pixels of one region arrive on the slave stream: s_tdata holds the 8-bit
// grey value, s_tlast marks the final pixel of the region. one pixel is taken
// per cycle while the two-entry summary queue has room.
// per region one item leaves on the master stream; m_tdata holds, from bit 0:
// mean [7:0], spread [15:8], similar [16], overflow [17], zeros above.
// the front keeps sum, count, min and max and pushes a summary on the last
// pixel; the back divides sum by count one quotient bit a cycle. after the last
// pixel is taken, its summary passes the queue, 8 division steps and the
// output register; the back finishes one region before it takes the next.
// regions shorter than the back's time per region are absorbed by the queue;
// when it fills, s_tready drops until the back catches up.
// a stalled receiver holds the result in the output register while the next
// division completes behind it.
// threshold is to be written via threshold_we only while the block is idle; the block itself does not enforce this.
// rst is synchronous: it clears the accumulators, the queue, the output valid
// and sets threshold to 0.
module region_mean_and_range_test_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        threshold_we,
  input  logic [7:0]  threshold,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // pixel [7:0]
  input  logic        s_tlast,   // last pixel of the region
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // mean [7:0], spread [15:8], similar [16], overflow [17]
);
  import rmr_pkg::*;

  region_t push_data;
  region_t pop_data;
  logic    push;
  logic    full;
  logic    pop;
  logic    not_empty;

  rmr_front u_front (
    .clk          (clk),
    .rst          (rst),
    .threshold_we (threshold_we),
    .threshold    (threshold),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .pixel        (s_tdata),
    .last         (s_tlast),
    .q_full       (full),
    .q_push       (push),
    .q_data       (push_data)
  );

  rmr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .pop_data  (pop_data)
  );

  rmr_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (not_empty),
    .q_data   (pop_data),
    .q_pop    (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

/* tb/region_mean_and_range_test_checker.sv */
module region_mean_and_range_test_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        threshold_we,
  input  logic [7:0]  threshold,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        s_tlast,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [23:0] m_tdata,
  output int          fail_count,
  output int          pending,
  output int          regions_done,
  output int          pixels_taken,
  output int          similar_seen,
  output int          overflow_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import rmr_pkg::*;

  typedef struct packed {
    logic [7:0] mean;
    logic [7:0] spread;
    logic       similar;
    logic       overflow;
  } region_summary_t;

  logic [25:0]     run_sum;
  logic [18:0]     run_count;
  logic [7:0]      run_min;
  logic [7:0]      run_max;
  logic            run_overflow;
  logic [7:0]      thr_now;
  region_summary_t summary_due_q[$];

  task automatic clear_region_state();
    run_sum      = '0;
    run_count    = '0;
    run_min      = 8'hFF;
    run_max      = 8'h00;
    run_overflow = 1'b0;
  endtask

  task automatic take_pixel(input logic [7:0] pix, input logic last);
    region_summary_t s;
    logic [7:0]      spread;
    pixels_taken++;
    // past the pixel limit only min and max keep moving
    if (run_count < MAX_REGION_PIXELS) begin
      run_sum   = run_sum + 26'(pix);
      run_count = run_count + 19'd1;
    end else begin
      run_overflow = 1'b1;
    end
    if (pix < run_min) run_min = pix;
    if (pix > run_max) run_max = pix;
    if (last) begin
      spread     = run_max - run_min;
      s.mean     = 8'(run_sum / 26'(run_count));
      s.spread   = spread;
      s.similar  = (spread <= thr_now);
      s.overflow = run_overflow;
      summary_due_q.push_back(s);
      regions_done++;
      if (s.similar) similar_seen++;
      if (s.overflow) overflow_seen++;
      clear_region_state();
    end
  endtask

  task automatic compare_field(input string what, input int want, input int got);
    if (want != got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endtask

  task automatic check_result(input logic [23:0] word);
    region_summary_t want;
    if (summary_due_q.size() == 0) begin
      fail_count++;
      $display("%0t: result with none expected, expected nothing, actual %h", $time, word);
    end else begin
      want = summary_due_q.pop_front();
      compare_field("mean", want.mean, word[7:0]);
      compare_field("spread", want.spread, word[15:8]);
      compare_field("similar", want.similar, word[16]);
      compare_field("overflow", want.overflow, word[17]);
      compare_field("padding", 0, word[23:18]);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_region_state();
      thr_now = 8'h00;
      summary_due_q.delete();
      fail_count    = 0;
      regions_done  = 0;
      pixels_taken  = 0;
      similar_seen  = 0;
      overflow_seen = 0;
    end else begin
      if (threshold_we) thr_now = threshold;
      if (s_tvalid && s_tready) take_pixel(s_tdata, s_tlast);
      if (m_tvalid && m_tready) check_result(m_tdata);
    end
    pending = summary_due_q.size();
  end

endmodule

/* tb/region_mean_and_range_test_core_tb.sv */
module region_mean_and_range_test_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT    = 200_000;
  localparam int SETTLE_CYCLES  = 16;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int PHASE_PIXELS   = 630;

  logic        clk;
  logic        rst;
  logic        threshold_we;
  logic [7:0]  threshold;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // pixel [7:0]
  logic        s_tlast;   // last pixel of the region
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;   // mean [7:0], spread [15:8], similar [16], overflow [17]

  int fail_count;
  int pending;
  int regions_done;
  int pixels_taken;
  int similar_seen;
  int overflow_seen;

  int tx_idle_pct;
  int tx_idle_now;
  int rx_idle_pct;
  int hold_requests;
  int pixels_sent;
  int cycle_count;
  logic [7:0] cur_threshold;

  region_mean_and_range_test_core uut (
    .clk          (clk),
    .rst          (rst),
    .threshold_we (threshold_we),
    .threshold    (threshold),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tlast      (s_tlast),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata)
  );

  region_mean_and_range_test_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .threshold_we  (threshold_we),
    .threshold     (threshold),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tlast       (s_tlast),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .fail_count    (fail_count),
    .pending       (pending),
    .regions_done  (regions_done),
    .pixels_taken  (pixels_taken),
    .similar_seen  (similar_seen),
    .overflow_seen (overflow_seen)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // receiver: random ready, short full-rate bursts, and a long hold-off on request
  initial begin
    int served;
    int burst_left;
    int hold_left;
    served     = 0;
    burst_left = 0;
    hold_left  = 0;
    m_tready   = 1'b0;
    forever begin
      @(negedge clk);
      if (served != hold_requests) begin
        served++;
        hold_left = RX_HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (burst_left != 0) begin
        burst_left--;
        m_tready <= 1'b1;
      end else begin
        if ($urandom_range(0, 99) == 0) burst_left = $urandom_range(10, 40);
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_pixel(input logic [7:0] pix, input logic last);
    while ($urandom_range(0, 99) < tx_idle_now) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= pix;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    pixels_sent++;
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_threshold(input logic [7:0] value);
    wait_idle();
    threshold_we  <= 1'b1;
    threshold     <= value;
    cur_threshold  = value;
    @(negedge clk);
    threshold_we  <= 1'b0;
  endtask

  task automatic send_random_region(input int max_len);
    int len;
    int pick;
    int style;
    int base;
    int width;
    int v;
    pick = $urandom_range(0, 9);
    if (pick < 6) len = $urandom_range(1, 4);
    else if (pick < 9) len = $urandom_range(5, 12);
    else len = $urandom_range(13, 40);
    if (len > max_len) len = $urandom_range(1, max_len);
    style = $urandom_range(0, 3);
    // narrow regions and regions whose spread sits at or just above the threshold
    width = (style == 1) ? $urandom_range(0, 6) : int'(cur_threshold) + $urandom_range(0, 2);
    if (width > 255) width = 255;
    base = $urandom_range(0, 255 - width);
    tx_idle_now = ($urandom_range(0, 7) == 0) ? 0 : tx_idle_pct;
    for (int i = 0; i < len; i++) begin
      case (style)
        0: v = $urandom_range(0, 255);
        2: v = $urandom_range(0, 1) ? 255 : 0;
        default: begin
          if (i == 0) v = base;
          else if (i == 1) v = base + width;
          else v = base + $urandom_range(0, width);
        end
      endcase
      send_pixel(8'(v), i == len - 1);
    end
  endtask

  task automatic run_random_regions(input int pixel_target, input int max_len);
    int stop_at;
    stop_at = pixels_sent + pixel_target;
    while (pixels_sent < stop_at) send_random_region(max_len);
  endtask

  initial begin
    rst           = 1'b1;
    threshold_we  = 1'b0;
    threshold     = 8'h00;
    s_tvalid      = 1'b0;
    s_tdata       = 8'h00;
    s_tlast       = 1'b0;
    tx_idle_pct   = 36;
    tx_idle_now   = 36;
    rx_idle_pct   = 86;
    hold_requests = 0;
    pixels_sent   = 0;
    cycle_count   = 0;
    cur_threshold = 8'h00;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: threshold still at its reset value of zero
    send_pixel(8'h00, 1'b1);
    send_pixel(8'hFF, 1'b1);
    send_pixel(8'h00, 1'b0);
    send_pixel(8'hFF, 1'b1);
    send_pixel(8'hFF, 1'b0);
    send_pixel(8'h00, 1'b1);
    send_pixel(8'h09, 1'b0);
    send_pixel(8'h09, 1'b0);
    send_pixel(8'h09, 1'b1);
    send_pixel(8'h01, 1'b0);
    send_pixel(8'h02, 1'b1);
    write_threshold(8'hFF);
    send_pixel(8'h00, 1'b0);
    send_pixel(8'hFF, 1'b1);
    send_pixel(8'hFF, 1'b0);
    send_pixel(8'hFE, 1'b1);
    write_threshold(8'h01);
    send_pixel(8'h01, 1'b0);
    send_pixel(8'h02, 1'b1);
    send_pixel(8'h01, 1'b0);
    send_pixel(8'h03, 1'b1);
    send_pixel(8'hAA, 1'b0);
    send_pixel(8'h55, 1'b1);

    write_threshold(8'($urandom_range(0, 255)));
    run_random_regions(PHASE_PIXELS, 40);

    tx_idle_pct = 86;
    rx_idle_pct = 36;
    write_threshold(8'h00);
    run_random_regions(PHASE_PIXELS, 40);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_threshold(8'($urandom_range(1, 254)));
    // receiver stops while short regions keep coming, so the summary queue fills up
    hold_requests++;
    run_random_regions(120, 2);
    run_random_regions(PHASE_PIXELS - 120, 40);

    wait_idle();
    $display("took %0d pixels in %0d regions: %0d similar, %0d over the pixel limit",
             pixels_taken, regions_done, similar_seen, overflow_seen);
    $display("idle mixes 36/86, 86/36 and none, plus a %0d-cycle receiver hold-off",
             RX_HOLD_CYCLES);
    if (fail_count == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

/* region_mean_and_range_test_core.f */
hdl/rmr_pkg.sv
hdl/rmr_front.sv
hdl/rmr_queue.sv
hdl/rmr_back.sv
hdl/region_mean_and_range_test_core.sv
tb/region_mean_and_range_test_checker.sv
tb/region_mean_and_range_test_core_tb.sv
